### src/tcc_pkg.sv
package tcc_pkg;

	localparam int SAMPLE_BITS         = 16;
	localparam int ANGLE_BITS          = 16;
	localparam int ANGLE_FRACTION_BITS = 13;
	localparam int VALUE_BITS          = 16;
	localparam int TRIG_BITS           = 17;
	localparam int COEF_BITS           = 18;
	localparam int NORTH_BITS          = 32;
	localparam int HEADING_BITS        = 18;
	localparam int SIGN_BITS           = 2;
	localparam int OFFSET_BITS         = 17;
	localparam int CFG_DATA_BITS       = 17;
	localparam int CFG_INDEX_BITS      = 3;

	localparam int CORDIC_STEPS = 24;
	localparam int QUOTIENT_BITS = 16;
	localparam int NORM_LATENCY = QUOTIENT_BITS + 3;
	localparam int SINCOS_LATENCY = CORDIC_STEPS + 3;
	localparam int ATAN2_LATENCY = CORDIC_STEPS + 2;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = PI_Q30 / 2;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
	localparam longint ONE_Q14 = 64'sd16384;

	localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
		32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
		32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
		32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
		32'sd1024,      32'sd512,       32'sd256,       32'sd128
	};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_X_MINIMUM      = 3'd0,
		REG_Y_MINIMUM      = 3'd1,
		REG_Z_MINIMUM      = 3'd2,
		REG_X_MAXIMUM      = 3'd3,
		REG_Y_MAXIMUM      = 3'd4,
		REG_Z_MAXIMUM      = 3'd5,
		REG_HEADING_SIGN   = 3'd6,
		REG_HEADING_OFFSET = 3'd7
	} tcc_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] raw_x;
		logic signed [SAMPLE_BITS-1:0] raw_y;
		logic signed [SAMPLE_BITS-1:0] raw_z;
		logic signed [ANGLE_BITS-1:0]  roll_angle;
		logic signed [ANGLE_BITS-1:0]  pitch_angle;
	} tcc_item_t;

	typedef struct packed {
		logic signed [HEADING_BITS-1:0] heading;
		logic                           span_error;
	} tcc_result_t;

endpackage

### src/tcc_norm.sv
module tcc_norm import tcc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  logic signed [SAMPLE_BITS-1:0] raw,
	input  logic signed [SAMPLE_BITS-1:0] lo,
	input  logic signed [SAMPLE_BITS-1:0] hi,
	input  logic                          negate,
	output logic                          valid_out,
	output logic signed [VALUE_BITS-1:0]  value
);

	localparam int NUM_W = SAMPLE_BITS + 2;
	localparam int DEN_W = SAMPLE_BITS + 1;
	localparam int D_W   = SAMPLE_BITS + 2;
	localparam int N_W   = NUM_W + 15;
	localparam int QB    = QUOTIENT_BITS;

	logic signed [NUM_W-1:0] num;
	logic signed [DEN_W-1:0] den;
	logic [NUM_W-1:0]        an;
	logic [DEN_W-1:0]        ad;

	logic [N_W-1:0] n_s1;
	logic [D_W-1:0] d_s1;
	logic           neg_s1;
	logic           vld_s1;

	logic [N_W-1:0] rem_s [QB+1];
	logic [D_W-1:0] div_s [QB+1];
	logic [QB-1:0]  quo_s [QB+1];
	logic           neg_s [QB+1];
	logic           ovf_s [QB+1];
	logic           vld_s [QB+1];

	logic signed [VALUE_BITS-1:0] qs;
	logic                         sat;

	always_comb begin
		num = (NUM_W'(raw) <<< 1) - NUM_W'(hi) - NUM_W'(lo);
		den = DEN_W'(hi) - DEN_W'(lo);
		an  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		ad  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		n_s1   <= (N_W'(an) << 15) + N_W'(ad);
		d_s1   <= {ad, 1'b0};
		neg_s1 <= num[NUM_W-1] ^ den[DEN_W-1] ^ negate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= n_s1;
		div_s[0] <= d_s1;
		quo_s[0] <= '0;
		neg_s[0] <= neg_s1;
		ovf_s[0] <= (D_W'(n_s1[N_W-1:QB]) >= d_s1);
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [N_W-1:0] trial;
		logic           take;

		always_comb begin
			trial = N_W'(div_s[k]) << (QB - 1 - k);
			take  = (rem_s[k] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? (rem_s[k] - trial) : rem_s[k];
			div_s[k+1] <= div_s[k];
			quo_s[k+1] <= {quo_s[k][QB-2:0], take};
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_comb begin
		sat = ovf_s[QB] | quo_s[QB][QB-1];
		qs  = $signed(VALUE_BITS'(quo_s[QB]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (sat) begin
			value <= neg_s[QB] ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else begin
			value <= neg_s[QB] ? -qs : qs;
		end
	end

endmodule

### src/tcc_sincos.sv
module tcc_sincos import tcc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic signed [ANGLE_BITS:0]  angle,
	output logic                        valid_out,
	output logic signed [TRIG_BITS-1:0] cos_q,
	output logic signed [TRIG_BITS-1:0] sin_q
);

	localparam int R_W = 34;
	localparam int C_W = 33;
	localparam int SHIFT = 30 - ANGLE_FRACTION_BITS;
	localparam logic signed [R_W-1:0] PI_R      = R_W'(PI_Q30);
	localparam logic signed [R_W-1:0] TWO_PI_R  = R_W'(2 * PI_Q30);
	localparam logic signed [R_W-1:0] HALF_PI_R = R_W'(HALF_PI_Q30);

	logic signed [R_W-1:0] r0;
	logic signed [R_W-1:0] r_s1;
	logic                  zero_s1;
	logic                  vld_s1;

	logic signed [C_W-1:0] cx [CORDIC_STEPS+1];
	logic signed [C_W-1:0] cy [CORDIC_STEPS+1];
	logic signed [C_W-1:0] cz [CORDIC_STEPS+1];
	logic                  neg_s [CORDIC_STEPS+1];
	logic                  zero_s [CORDIC_STEPS+1];
	logic                  vld_s [CORDIC_STEPS+1];

	logic signed [C_W-1:0] xo;
	logic signed [C_W-1:0] yo;
	logic signed [C_W-1:0] xr;
	logic signed [C_W-1:0] yr;

	assign r0 = R_W'(angle) <<< SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (angle == '0);
		if (r0 > PI_R) begin
			r_s1 <= r0 - TWO_PI_R;
		end else if (r0 < -PI_R) begin
			r_s1 <= r0 + TWO_PI_R;
		end else begin
			r_s1 <= r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cx[0]     <= C_W'(CORDIC_GAIN_Q30);
		cy[0]     <= '0;
		zero_s[0] <= zero_s1;
		if (r_s1 > HALF_PI_R) begin
			cz[0]    <= C_W'(r_s1 - PI_R);
			neg_s[0] <= 1'b1;
		end else if (r_s1 < -HALF_PI_R) begin
			cz[0]    <= C_W'(r_s1 + PI_R);
			neg_s[0] <= 1'b1;
		end else begin
			cz[0]    <= C_W'(r_s1);
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic signed [C_W-1:0] dx;
		logic signed [C_W-1:0] dy;
		logic signed [C_W-1:0] da;

		always_comb begin
			dx = cy[k] >>> k;
			dy = cx[k] >>> k;
			da = C_W'(ATAN_TAB[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			if (!cz[k][C_W-1]) begin
				cx[k+1] <= cx[k] - dx;
				cy[k+1] <= cy[k] + dy;
				cz[k+1] <= cz[k] - da;
			end else begin
				cx[k+1] <= cx[k] + dx;
				cy[k+1] <= cy[k] - dy;
				cz[k+1] <= cz[k] + da;
			end
		end
	end

	always_comb begin
		xo = neg_s[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
		yo = neg_s[CORDIC_STEPS] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
		xr = xo + C_W'(33'sd32768);
		yr = yo + C_W'(33'sd32768);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[CORDIC_STEPS]) begin
			cos_q <= TRIG_BITS'(ONE_Q14);
			sin_q <= '0;
		end else begin
			cos_q <= xr[16+TRIG_BITS-1:16];
			sin_q <= yr[16+TRIG_BITS-1:16];
		end
	end

endmodule

### src/tcc_atan2.sv
module tcc_atan2 import tcc_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_in,
	input  logic signed [NORTH_BITS-1:0]   x_in,
	input  logic signed [NORTH_BITS-1:0]   y_in,
	output logic                           valid_out,
	output logic signed [HEADING_BITS-1:0] angle
);

	localparam int A_W = 35;
	localparam int Z_W = 34;
	localparam int H_W = 36;
	localparam int SHIFT = 30 - ANGLE_FRACTION_BITS;
	localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q30);

	logic signed [A_W-1:0] ax [CORDIC_STEPS+1];
	logic signed [A_W-1:0] ay [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] az [CORDIC_STEPS+1];
	logic                  zero_s [CORDIC_STEPS+1];
	logic                  vld_s [CORDIC_STEPS+1];

	logic signed [A_W-1:0] xe;
	logic signed [A_W-1:0] ye;
	logic signed [H_W-1:0] hr;

	assign xe = A_W'(x_in);
	assign ye = A_W'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in[NORTH_BITS-1] && !y_in[NORTH_BITS-1]) begin
			ax[0] <= ye;
			ay[0] <= -xe;
			az[0] <= HALF_PI_Z;
		end else if (x_in[NORTH_BITS-1]) begin
			ax[0] <= -ye;
			ay[0] <= xe;
			az[0] <= -HALF_PI_Z;
		end else begin
			ax[0] <= xe;
			ay[0] <= ye;
			az[0] <= '0;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
		logic signed [A_W-1:0] dx;
		logic signed [A_W-1:0] dy;
		logic signed [Z_W-1:0] da;

		always_comb begin
			dx = ay[k] >>> k;
			dy = ax[k] >>> k;
			da = Z_W'(ATAN_TAB[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			zero_s[k+1] <= zero_s[k];
			if (!ay[k][A_W-1]) begin
				ax[k+1] <= ax[k] + dx;
				ay[k+1] <= ay[k] - dy;
				az[k+1] <= az[k] + da;
			end else begin
				ax[k+1] <= ax[k] - dx;
				ay[k+1] <= ay[k] + dy;
				az[k+1] <= az[k] - da;
			end
		end
	end

	assign hr = H_W'(1) <<< (SHIFT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[CORDIC_STEPS]) begin
			angle <= '0;
		end else begin
			angle <= HEADING_BITS'((hr - H_W'(az[CORDIC_STEPS])) >>> SHIFT);
		end
	end

endmodule

### src/tilt_compensated_compass_core.sv
// Tilt-compensated compass heading, fully pipelined.
// An input word (three raw magnetometer axes, roll and pitch in Q3.13 radians)
// is taken at every rising edge at which start is high; busy is never raised, so
// a new word may be presented in every cycle.
// Each word yields exactly one result word on result, marked by done for one
// cycle, once it has passed through the 16-stage restoring divider and the
// 24-stage sine/cosine CORDIC running side by side, four multiply and add
// stages, the 24-stage vectoring CORDIC and one output stage.
// Throughput is one word per cycle.
// Calibration, heading sign and heading offset are written through wr_en,
// wr_index and wr_data, and must only change while no word is in flight.
// Reset clears all valid bits, so no result appears until a word is taken, and
// returns the registers to full-scale calibration, sign one and offset zero.
// The receiver cannot stall: a result is present for its single cycle only.
module tilt_compensated_compass_core import tcc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  tcc_item_t                 item,
	output logic                      done,
	output tcc_result_t               result,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data
);

	localparam int DLY = SINCOS_LATENCY - NORM_LATENCY;
	localparam int PROD_W = 34;
	localparam int SUM_W = 36;
	localparam int SCALED_W = HEADING_BITS + 2;
	localparam logic signed [SCALED_W-1:0] H_MAX = SCALED_W'(131071);
	localparam logic signed [SCALED_W-1:0] H_MIN = -SCALED_W'(131072);

	logic signed [SAMPLE_BITS-1:0] min_q [3];
	logic signed [SAMPLE_BITS-1:0] max_q [3];
	logic signed [SIGN_BITS-1:0]   sign_q;
	logic signed [OFFSET_BITS-1:0] offset_q;

	logic signed [SAMPLE_BITS-1:0] raw [3];
	logic signed [VALUE_BITS-1:0]  nv [3];
	logic                          nv_vld [3];
	logic signed [VALUE_BITS-1:0]  v_dly [3][DLY];
	logic                          vld_dly [DLY];

	logic                        acc;
	logic signed [ANGLE_BITS:0]  neg_pitch;
	logic                        sr_vld;
	logic                        sp_vld;
	logic signed [TRIG_BITS-1:0] ct;
	logic signed [TRIG_BITS-1:0] st;
	logic signed [TRIG_BITS-1:0] cp;
	logic signed [TRIG_BITS-1:0] sp;

	logic                         vld_s1;
	logic signed [PROD_W-1:0]     stsp_p_s1;
	logic signed [PROD_W-1:0]     stcp_p_s1;
	logic signed [TRIG_BITS-1:0]  ct_s1;
	logic signed [TRIG_BITS-1:0]  cp_s1;
	logic signed [TRIG_BITS-1:0]  sp_s1;
	logic signed [VALUE_BITS-1:0] v_s1 [3];

	logic                         vld_s2;
	logic signed [COEF_BITS-1:0]  stsp_s2;
	logic signed [COEF_BITS-1:0]  stcp_s2;
	logic signed [TRIG_BITS-1:0]  ct_s2;
	logic signed [TRIG_BITS-1:0]  cp_s2;
	logic signed [TRIG_BITS-1:0]  sp_s2;
	logic signed [VALUE_BITS-1:0] v_s2 [3];
	logic signed [PROD_W:0]       stsp_r;
	logic signed [PROD_W:0]       stcp_r;

	logic                     vld_s3;
	logic signed [PROD_W-1:0] p_s3 [5];

	logic                         vld_s4;
	logic signed [NORTH_BITS-1:0] n0_s4;
	logic signed [NORTH_BITS-1:0] n1_s4;
	logic signed [SUM_W-1:0]      n0_sum;
	logic signed [SUM_W-1:0]      n1_sum;

	logic                           at_vld;
	logic signed [HEADING_BITS-1:0] at_h;
	logic signed [SCALED_W-1:0]     h_ext;
	logic signed [SCALED_W-1:0]     h_scaled;
	logic signed [SCALED_W-1:0]     h_sum;
	logic                           span_zero;

	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign raw[0] = item.raw_x;
	assign raw[1] = item.raw_y;
	assign raw[2] = item.raw_z;
	assign neg_pitch = -((ANGLE_BITS+1)'(item.pitch_angle));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
				max_q[i] <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			end
			sign_q   <= SIGN_BITS'(1);
			offset_q <= '0;
		end else if (wr_en) begin
			case (tcc_reg_t'(wr_index))
				REG_X_MINIMUM:      min_q[0] <= wr_data[SAMPLE_BITS-1:0];
				REG_Y_MINIMUM:      min_q[1] <= wr_data[SAMPLE_BITS-1:0];
				REG_Z_MINIMUM:      min_q[2] <= wr_data[SAMPLE_BITS-1:0];
				REG_X_MAXIMUM:      max_q[0] <= wr_data[SAMPLE_BITS-1:0];
				REG_Y_MAXIMUM:      max_q[1] <= wr_data[SAMPLE_BITS-1:0];
				REG_Z_MAXIMUM:      max_q[2] <= wr_data[SAMPLE_BITS-1:0];
				REG_HEADING_SIGN:   sign_q   <= wr_data[SIGN_BITS-1:0];
				REG_HEADING_OFFSET: offset_q <= wr_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		tcc_norm u_norm (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (acc),
			.raw       (raw[a]),
			.lo        (min_q[a]),
			.hi        (max_q[a]),
			.negate    (a != 1),
			.valid_out (nv_vld[a]),
			.value     (nv[a])
		);

		always_ff @(posedge clk) begin
			v_dly[a][0] <= nv[a];
			for (int j = 1; j < DLY; j++) begin
				v_dly[a][j] <= v_dly[a][j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DLY; j++) begin
				vld_dly[j] <= 1'b0;
			end
		end else begin
			vld_dly[0] <= nv_vld[0] & nv_vld[1] & nv_vld[2];
			for (int j = 1; j < DLY; j++) begin
				vld_dly[j] <= vld_dly[j-1];
			end
		end
	end

	tcc_sincos u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (acc),
		.angle     ((ANGLE_BITS+1)'(item.roll_angle)),
		.valid_out (sr_vld),
		.cos_q     (ct),
		.sin_q     (st)
	);

	tcc_sincos u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (acc),
		.angle     (neg_pitch),
		.valid_out (sp_vld),
		.cos_q     (cp),
		.sin_q     (sp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= sr_vld & sp_vld & vld_dly[DLY-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		stsp_p_s1 <= st * sp;
		stcp_p_s1 <= st * cp;
		ct_s1     <= ct;
		cp_s1     <= cp;
		sp_s1     <= sp;
		for (int i = 0; i < 3; i++) begin
			v_s1[i] <= v_dly[i][DLY-1];
		end
	end

	always_comb begin
		stsp_r = (PROD_W+1)'(stsp_p_s1) + (PROD_W+1)'(8192);
		stcp_r = (PROD_W+1)'(stcp_p_s1) + (PROD_W+1)'(8192);
	end

	always_ff @(posedge clk) begin
		stsp_s2 <= stsp_r[14+COEF_BITS-1:14];
		stcp_s2 <= stcp_r[14+COEF_BITS-1:14];
		ct_s2   <= ct_s1;
		cp_s2   <= cp_s1;
		sp_s2   <= sp_s1;
		v_s2    <= v_s1;
	end

	always_ff @(posedge clk) begin
		p_s3[0] <= ct_s2 * v_s2[0];
		p_s3[1] <= stsp_s2 * v_s2[1];
		p_s3[2] <= stcp_s2 * v_s2[2];
		p_s3[3] <= cp_s2 * v_s2[1];
		p_s3[4] <= sp_s2 * v_s2[2];
	end

	always_comb begin
		n0_sum = SUM_W'(p_s3[0]) + SUM_W'(p_s3[1]) + SUM_W'(p_s3[2]);
		n1_sum = SUM_W'(p_s3[3]) - SUM_W'(p_s3[4]);
	end

	always_ff @(posedge clk) begin
		n0_s4 <= n0_sum[NORTH_BITS-1:0];
		n1_s4 <= n1_sum[NORTH_BITS-1:0];
	end

	tcc_atan2 u_atan2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (vld_s4),
		.x_in      (n0_s4),
		.y_in      (n1_s4),
		.valid_out (at_vld),
		.angle     (at_h)
	);

	always_comb begin
		h_ext = SCALED_W'(at_h);
		case (sign_q)
			2'sb01:  h_scaled = h_ext;
			2'sb11:  h_scaled = -h_ext;
			2'sb10:  h_scaled = -(h_ext <<< 1);
			default: h_scaled = '0;
		endcase
		h_sum = h_scaled + SCALED_W'(offset_q);
		span_zero = (max_q[0] == min_q[0]) | (max_q[1] == min_q[1]) |
			(max_q[2] == min_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= at_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.span_error <= span_zero;
		if (span_zero) begin
			result.heading <= '0;
		end else if (h_sum > H_MAX) begin
			result.heading <= HEADING_BITS'(H_MAX);
		end else if (h_sum < H_MIN) begin
			result.heading <= HEADING_BITS'(H_MIN);
		end else begin
			result.heading <= HEADING_BITS'(h_sum);
		end
	end

endmodule

### bench/tilt_compensated_compass_core_tb.sv
`timescale 1ns / 100ps

module tilt_compensated_compass_core_tb;
	import tcc_pkg::*;

	localparam int PIPE_CYCLES = 58;
	localparam longint ANGLE_MAX = 25736;

	typedef struct {
		tcc_item_t   word;
		bit          typed;
		tcc_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tcc_item_t   item;
	logic        done;
	tcc_result_t result;
	logic        wr_en;
	logic [CFG_INDEX_BITS-1:0] wr_index;
	logic [CFG_DATA_BITS-1:0]  wr_data;

	longint cal_lo [3];
	longint cal_hi [3];
	longint head_mult;
	longint head_offs;
	longint arc_step [CORDIC_STEPS];

	tcc_result_t pending_headings [$];
	int  fails;
	int  words_sent;
	int  words_checked;
	int  error_words;

	tilt_compensated_compass_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#1000000;
		$display("tb: failure");
		$finish;
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic void build_arcs();
		longint acc, t;
		int e;
		arc_step[0] = (PI_Q30 + 2) >>> 2;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			acc = 0;
			for (int k = 0; k < 64; k++) begin
				e = i * (2 * k + 1);
				if (e > 60)
					break;
				t = (longint'(1) << (60 - e)) / (2 * k + 1);
				acc = (k & 1) ? acc - t : acc + t;
			end
			arc_step[i] = (acc + (longint'(1) << 29)) >>> 30;
		end
	endfunction

	function automatic void trig_q14(longint a, output longint c, output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		flip = 0;
		if (a == 0) begin
			c = ONE_Q14;
			s = 0;
			return;
		end
		r = (a * (longint'(1) << (30 - ANGLE_FRACTION_BITS))) % (2 * PI_Q30);
		if (r > PI_Q30) r -= 2 * PI_Q30;
		if (r < -PI_Q30) r += 2 * PI_Q30;
		if (r > PI_Q30 / 2) begin
			r -= PI_Q30;
			flip = 1;
		end else if (r < -(PI_Q30 / 2)) begin
			r += PI_Q30;
			flip = 1;
		end
		x = CORDIC_GAIN_Q30;
		y = 0;
		z = r;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step[i];
			end else begin
				x += dx; y -= dy; z += arc_step[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_shift(x, 16);
		s = round_shift(y, 16);
	endfunction

	function automatic longint bearing_q30(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = PI_Q30 / 2;
			end else begin
				t = -y; y = x; x = t; z = -(PI_Q30 / 2);
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arc_step[i];
			end else begin
				x -= dx; y += dy; z -= arc_step[i];
			end
		end
		return z;
	endfunction

	function automatic longint scale_axis(longint raw, longint lo, longint hi, bit negate);
		longint num, den, an, ad, q;
		bit neg;
		num = (2 * raw - hi - lo) * ONE_Q14;
		den = hi - lo;
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		neg = ((num < 0) != (den < 0)) != negate;
		if (neg) q = -q;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q;
	endfunction

	function automatic tcc_result_t predict_heading(tcc_item_t w);
		tcc_result_t r;
		longint raw [3];
		longint v [3];
		longint ct, st, cp, sp, stsp, stcp, n0, n1, h;
		raw[0] = w.raw_x;
		raw[1] = w.raw_y;
		raw[2] = w.raw_z;
		r.heading = '0;
		r.span_error = 1'b1;
		for (int i = 0; i < 3; i++)
			if (cal_hi[i] == cal_lo[i])
				return r;
		for (int i = 0; i < 3; i++)
			v[i] = scale_axis(raw[i], cal_lo[i], cal_hi[i], i != 1);
		trig_q14(longint'(w.roll_angle), ct, st);
		trig_q14(-longint'(w.pitch_angle), cp, sp);
		stsp = round_shift(st * sp, 14);
		stcp = round_shift(st * cp, 14);
		n0 = ct * v[0] + stsp * v[1] + stcp * v[2];
		n1 = cp * v[1] - sp * v[2];
		h = round_shift(-bearing_q30(n1, n0), 30 - ANGLE_FRACTION_BITS);
		h = h * head_mult + head_offs;
		if (h > 131071) h = 131071;
		if (h < -131072) h = -131072;
		r.heading = h[HEADING_BITS-1:0];
		r.span_error = 1'b0;
		return r;
	endfunction

	function automatic tcc_item_t make_word(longint x, longint y, longint z, longint rl,
			longint pt);
		tcc_item_t w;
		w.raw_x = x[15:0];
		w.raw_y = y[15:0];
		w.raw_z = z[15:0];
		w.roll_angle = rl[15:0];
		w.pitch_angle = pt[15:0];
		return w;
	endfunction

	function automatic longint rand_angle();
		case ($urandom_range(0, 9))
			0: return ANGLE_MAX;
			1: return -ANGLE_MAX;
			2: return 0;
			default: return longint'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
		endcase
	endfunction

	function automatic longint rand_raw(int axis);
		longint lo, hi;
		lo = cal_lo[axis] < cal_hi[axis] ? cal_lo[axis] : cal_hi[axis];
		hi = cal_lo[axis] < cal_hi[axis] ? cal_hi[axis] : cal_lo[axis];
		if ($urandom_range(0, 3) == 0)
			return longint'($urandom_range(0, 65535)) - 32768;
		return longint'($urandom_range(0, int'(hi - lo))) + lo;
	endfunction

	task automatic write_reg(tcc_reg_t idx, longint val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[CFG_DATA_BITS-1:0];
		case (idx)
			REG_X_MINIMUM, REG_Y_MINIMUM, REG_Z_MINIMUM:
				cal_lo[idx] = longint'($signed(val[15:0]));
			REG_X_MAXIMUM, REG_Y_MAXIMUM, REG_Z_MAXIMUM:
				cal_hi[idx - REG_X_MAXIMUM] = longint'($signed(val[15:0]));
			REG_HEADING_SIGN:
				head_mult = longint'($signed(val[1:0]));
			REG_HEADING_OFFSET:
				head_offs = longint'($signed(val[16:0]));
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic send_word(tcc_item_t w, bit typed, tcc_result_t known);
		bit taken;
		start <= 1'b1;
		item <= w;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				taken = 1;
				pending_headings.push_back(typed ? known : predict_heading(w));
				words_sent++;
			end
			@(negedge clk);
		end
	endtask

	task automatic pause_sender();
		start <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain_pipe();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_headings.size() != 0 && guard < 10000) begin
			@(negedge clk);
			guard++;
		end
		repeat (PIPE_CYCLES + 4) @(negedge clk);
	endtask

	task automatic send_random(int count);
		int burst;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 2) != 0)
					pause_sender();
			end
			burst--;
			send_word(make_word(rand_raw(0), rand_raw(1), rand_raw(2), rand_angle(),
				rand_angle()), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		tcc_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_headings.size() == 0) begin
				$error("unexpected result word heading=%0d span_error=%0b",
					result.heading, result.span_error);
				fails++;
			end else begin
				want = pending_headings.pop_front();
				words_checked++;
				if (result.span_error)
					error_words++;
				if (result.heading !== want.heading) begin
					$error("heading: expected %0d, got %0d", want.heading, result.heading);
					fails++;
				end
				if (result.span_error !== want.span_error) begin
					$error("span_error: expected %0b, got %0b", want.span_error,
						result.span_error);
					fails++;
				end
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		longint lo;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = REG_X_MINIMUM;
		wr_data = '0;
		fails = 0;
		words_sent = 0;
		words_checked = 0;
		error_words = 0;
		for (int i = 0; i < 3; i++) begin
			cal_lo[i] = -32768;
			cal_hi[i] = 32767;
		end
		head_mult = 1;
		head_offs = 0;
		build_arcs();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A centred sample with full-scale calibration is the zero vector.
		row.typed = 1;
		row.res = '0;
		row.word = make_word(0, 0, 0, 0, 0);
		rows.push_back(row);
		row.word = make_word(0, 0, 0, ANGLE_MAX, -ANGLE_MAX);
		rows.push_back(row);
		row.typed = 0;
		row.word = make_word(32767, 32767, 32767, 0, 0);
		rows.push_back(row);
		row.word = make_word(-32768, -32768, -32768, 0, 0);
		rows.push_back(row);
		row.word = make_word(32767, -32768, 0, ANGLE_MAX, ANGLE_MAX);
		rows.push_back(row);
		row.word = make_word(-32768, 32767, 32767, -ANGLE_MAX, -ANGLE_MAX);
		rows.push_back(row);
		row.word = make_word(16000, -9000, 4000, 12868, 0);
		rows.push_back(row);
		row.word = make_word(-16000, 9000, -4000, 0, -12868);
		rows.push_back(row);
		row.word = make_word(0, 20000, 0, 6434, 6434);
		rows.push_back(row);
		row.word = make_word(-1, 0, -1, 1, -1);
		rows.push_back(row);
		row.word = make_word(30000, 30000, -30000, -6434, 19302);
		rows.push_back(row);
		row.word = make_word(-20000, 0, 0, 25000, -25000);
		rows.push_back(row);
		foreach (rows[i]) begin
			send_word(rows[i].word, rows[i].typed, rows[i].res);
			if (i % 3 == 2)
				pause_sender();
		end
		send_random(140);
		drain_pipe();

		// Narrow calibration, inverted sign and a positive offset of 51472.
		write_reg(REG_X_MINIMUM, -1200);
		write_reg(REG_Y_MINIMUM, -800);
		write_reg(REG_Z_MINIMUM, -3000);
		write_reg(REG_X_MAXIMUM, 1500);
		write_reg(REG_Y_MAXIMUM, 900);
		write_reg(REG_Z_MAXIMUM, 2000);
		write_reg(REG_HEADING_SIGN, -1);
		write_reg(REG_HEADING_OFFSET, 51472);
		send_random(150);
		drain_pipe();

		// Doubling negated heading with an offset of minus 51472.
		write_reg(REG_HEADING_SIGN, -2);
		write_reg(REG_HEADING_OFFSET, -51472);
		send_random(130);
		drain_pipe();

		// A zero span on y flags every word as a calibration error.
		write_reg(REG_Y_MAXIMUM, -800);
		send_word(make_word(100, 200, 300, 0, 0), 1'b1, '{heading: '0, span_error: 1'b1});
		send_word(make_word(-32768, 32767, 0, ANGLE_MAX, -ANGLE_MAX), 1'b1,
			'{heading: '0, span_error: 1'b1});
		send_random(60);
		drain_pipe();

		// Maximum below minimum flips the axes; a zero sign leaves only the offset.
		write_reg(REG_X_MINIMUM, 32767);
		write_reg(REG_X_MAXIMUM, -32768);
		write_reg(REG_Y_MINIMUM, 5000);
		write_reg(REG_Y_MAXIMUM, -5000);
		write_reg(REG_Z_MINIMUM, 100);
		write_reg(REG_Z_MAXIMUM, 99);
		write_reg(REG_HEADING_SIGN, 1);
		write_reg(REG_HEADING_OFFSET, 1000);
		send_random(150);
		drain_pipe();
		write_reg(REG_HEADING_SIGN, 0);
		send_random(60);
		drain_pipe();

		for (int ph = 0; ph < 4; ph++) begin
			for (int a = 0; a < 3; a++) begin
				lo = longint'($urandom_range(0, 65535)) - 32768;
				write_reg(tcc_reg_t'(REG_X_MINIMUM + a), lo);
				if ($urandom_range(0, 7) == 0)
					write_reg(tcc_reg_t'(REG_X_MAXIMUM + a), lo);
				else
					write_reg(tcc_reg_t'(REG_X_MAXIMUM + a),
						longint'($urandom_range(0, 65535)) - 32768);
			end
			write_reg(REG_HEADING_SIGN, $urandom_range(0, 3));
			write_reg(REG_HEADING_OFFSET, longint'($urandom_range(0, 102944)) - 51472);
			send_random(90);
			drain_pipe();
		end

		if (pending_headings.size() != 0) begin
			$error("%0d expected result words never arrived", pending_headings.size());
			fails++;
		end
		$display("Sent %0d words across ten calibration settings; %0d results checked,",
			words_sent, words_checked);
		$display("%0d of them calibration errors, with %0d failures.", error_words, fails);
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
